[rtl/core/kip_pkg.sv]
// kip_pkg: shared types, constants and microcode rom of the keyed index permutation
// holds mixing constants, control word layout and the sequencer program
// no dependencies

package kip_pkg;

    // fixed widths
    localparam int INDEX_BITS_DEFAULT = 32;
    localparam int MIX_W              = 64;
    localparam int MUL_W              = 32;
    localparam int CFG_IDX_W          = 1;
    localparam int CFG_DATA_W         = 64;
    localparam int PC_W               = 4;
    localparam int RND_W              = 2;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_DOMAIN_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_SEED    = 1'b1;

    // feistel and mixer constants
    localparam logic [RND_W-1:0] FEISTEL_ROUNDS = 2'd3;
    localparam logic [RND_W-1:0] FIRST_ROUND    = 2'd1;
    localparam logic [MIX_W-1:0] GOLDEN_STEP    = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [MIX_W-1:0] MIX_MUL_A      = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [MIX_W-1:0] MIX_MUL_B      = 64'h94D0_49BB_1331_11EB;
    localparam int               XS_PRE         = 30;
    localparam int               XS_MID         = 27;
    localparam int               XS_POST        = 31;

    // sequencer state
    typedef enum logic
    {
        SEQ_IDLE,
        SEQ_RUN
    } seq_state_t;

    // datapath operations
    typedef enum logic [3:0]
    {
        UOP_CHECK,
        UOP_SMEAR,
        UOP_GEOM,
        UOP_SPLIT,
        UOP_PREMIX,
        UOP_MUL_LL,
        UOP_MUL_LH,
        UOP_MUL_HL,
        UOP_XS_MID,
        UOP_APPLY,
        UOP_JOIN,
        UOP_TEST
    } uop_t;

    // multiplier constant select
    typedef enum logic
    {
        MC_A,
        MC_B
    } mconst_t;

    // sequencing of the step counter
    typedef enum logic [1:0]
    {
        BR_NEXT,   // fall through
        BR_GUARD,  // finish with error when the index is out of range
        BR_ROUND,  // loop back while rounds remain
        BR_WALK    // walk again while the value is out of range, else finish
    } branch_t;

    typedef struct packed
    {
        uop_t             op;
        mconst_t          mc;
        branch_t          br;
        logic [PC_W-1:0]  target;
    } ucode_word_t;

    // program entry points
    localparam logic [PC_W-1:0] ENTRY_START = 4'd0;
    localparam logic [PC_W-1:0] ENTRY_PASS  = 4'd3;
    localparam logic [PC_W-1:0] ENTRY_ROUND = 4'd4;

    // microcode rom
    function automatic ucode_word_t ucode(input logic [PC_W-1:0] pc);
        ucode_word_t w;
        case (pc)
            4'd0:    w = '{UOP_CHECK,  MC_A, BR_GUARD, ENTRY_START};
            4'd1:    w = '{UOP_SMEAR,  MC_A, BR_NEXT,  ENTRY_START};
            4'd2:    w = '{UOP_GEOM,   MC_A, BR_NEXT,  ENTRY_START};
            4'd3:    w = '{UOP_SPLIT,  MC_A, BR_NEXT,  ENTRY_START};
            4'd4:    w = '{UOP_PREMIX, MC_A, BR_NEXT,  ENTRY_START};
            4'd5:    w = '{UOP_MUL_LL, MC_A, BR_NEXT,  ENTRY_START};
            4'd6:    w = '{UOP_MUL_LH, MC_A, BR_NEXT,  ENTRY_START};
            4'd7:    w = '{UOP_MUL_HL, MC_A, BR_NEXT,  ENTRY_START};
            4'd8:    w = '{UOP_XS_MID, MC_A, BR_NEXT,  ENTRY_START};
            4'd9:    w = '{UOP_MUL_LL, MC_B, BR_NEXT,  ENTRY_START};
            4'd10:   w = '{UOP_MUL_LH, MC_B, BR_NEXT,  ENTRY_START};
            4'd11:   w = '{UOP_MUL_HL, MC_B, BR_NEXT,  ENTRY_START};
            4'd12:   w = '{UOP_APPLY,  MC_A, BR_ROUND, ENTRY_ROUND};
            4'd13:   w = '{UOP_JOIN,   MC_A, BR_NEXT,  ENTRY_START};
            4'd14:   w = '{UOP_TEST,   MC_A, BR_WALK,  ENTRY_PASS};
            default: w = '{UOP_CHECK,  MC_A, BR_GUARD, ENTRY_START};
        endcase
        return w;
    endfunction

    // key offset of each round: golden step times round number
    function automatic logic [MIX_W-1:0] round_offset(input logic [RND_W-1:0] rnd);
        logic [MIX_W-1:0] off;
        case (rnd)
            2'd1:    off = GOLDEN_STEP;
            2'd2:    off = GOLDEN_STEP << 1;
            2'd3:    off = GOLDEN_STEP + (GOLDEN_STEP << 1);
            default: off = '0;
        endcase
        return off;
    endfunction

endpackage

[rtl/core/keyed_index_permutation.sv]
// keyed index permutation: one request transaction in, one result transaction out
// a rejected index finishes at the range guard; otherwise the value runs p cycle-walking passes,
//   where p >= 1 (under two on average)
// no new request is taken until the last result is in the output register;
//   each pass is three rounds of two 64-bit products on one shared 32x32 multiplier
// reset: async active low; domain size 1, key 0, sequencer idle, no result pending
// depends on kip_pkg (constants, control word layout, microcode rom)

module keyed_index_permutation #(
    parameter int INDEX_BITS = kip_pkg::INDEX_BITS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,

    // configuration write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [kip_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [kip_pkg::CFG_DATA_W-1:0]   cfg_data,

    // request channel
    input  logic                             source_valid,
    output logic                             source_ready,
    input  logic [INDEX_BITS-1:0]            source_index,

    // result channel
    output logic                             result_valid,
    input  logic                             result_ready,
    output logic [INDEX_BITS-1:0]            permuted_index,
    output logic                             bad_request
);

    // domain register is one bit wider than the index, capped at the mixer width
    localparam int DS_W    = (INDEX_BITS + 1 > kip_pkg::MIX_W) ? kip_pkg::MIX_W
                                                               : INDEX_BITS + 1;
    // the walked value can need every bit of the domain size
    localparam int VAL_W   = DS_W;
    localparam int HALF_W  = (VAL_W + 1) / 2;
    localparam int SHIFT_W = $clog2(VAL_W + 1);
    localparam int PC_W    = kip_pkg::PC_W;
    localparam int MIX_W   = kip_pkg::MIX_W;
    localparam int MUL_W   = kip_pkg::MUL_W;
    localparam int RND_W   = kip_pkg::RND_W;

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------

    // configuration
    logic [DS_W-1:0]           domain_reg, domain_next;
    logic [MIX_W-1:0]          key_reg, key_next;

    // sequencer control
    kip_pkg::seq_state_t       state_reg, state_next;
    logic [PC_W-1:0]           pc_reg, pc_next;
    logic [RND_W-1:0]          rnd_reg, rnd_next;

    // geometry of the current domain: value width mask, half widths and masks
    logic [VAL_W-1:0]          bmask_reg, bmask_next;
    logic [SHIFT_W-1:0]        lo_w_reg, lo_w_next;
    logic [HALF_W-1:0]         lo_m_reg, lo_m_next;
    logic [HALF_W-1:0]         hi_m_reg, hi_m_next;

    // walked value, feistel halves and mixer registers
    logic [VAL_W-1:0]          val_reg, val_next;
    logic [HALF_W-1:0]         hi_reg, hi_next;
    logic [HALF_W-1:0]         lo_reg, lo_next;
    logic [MIX_W-1:0]          h_reg, h_next;
    logic [MIX_W-1:0]          acc_reg, acc_next;

    // output register, parts the sequencer from the result consumer
    logic                      res_valid_reg, res_valid_next;
    logic [INDEX_BITS-1:0]     perm_reg, perm_next;
    logic                      bad_reg, bad_next;

    // ------------------------------------------------------------------
    // combinational datapath
    // ------------------------------------------------------------------

    kip_pkg::ucode_word_t      ctrl;
    logic                      val_ge;
    logic                      out_free;

    logic [VAL_W-1:0]          smear;
    logic [VAL_W-1:0]          onehot;
    logic [SHIFT_W-1:0]        width_b;
    logic [SHIFT_W-1:0]        lo_w_calc;
    logic [HALF_W-1:0]         lo_m_calc;
    logic [HALF_W-1:0]         hi_m_calc;

    logic [MIX_W-1:0]          mix_src;
    logic [MIX_W-1:0]          keyed;
    logic [MIX_W-1:0]          premix;
    logic [MIX_W-1:0]          mid_mix;
    logic [MIX_W-1:0]          final_mix;
    logic [MIX_W-1:0]          mconst;
    logic [MUL_W-1:0]          mul_a;
    logic [MUL_W-1:0]          mul_b;
    logic [2*MUL_W-1:0]        prod;

    logic [HALF_W-1:0]         split_hi;
    logic [HALF_W-1:0]         split_lo;
    logic [VAL_W-1:0]          joined;

    logic                      finish;
    logic                      finish_bad;

    // control word of the current step
    assign ctrl = kip_pkg::ucode(pc_reg);

    // one comparator serves the range guard and the walk test
    assign val_ge   = (val_reg >= domain_reg);
    assign out_free = !res_valid_reg || result_ready;

    // domain geometry: smear n-1 into a run of ones, then width and half masks
    always_comb
    begin
        smear = domain_reg - DS_W'(1);
        for (int s = 1; s < VAL_W; s = s * 2)
        begin
            smear = smear | (smear >> s);
        end

        // top of the run of ones marks the width b
        onehot  = bmask_reg & ~(bmask_reg >> 1);
        width_b = '0;
        for (int i = 0; i < VAL_W; i++)
        begin
            if (onehot[i])
            begin
                width_b = width_b | SHIFT_W'(i + 1);
            end
        end

        lo_w_calc = width_b >> 1;
        for (int i = 0; i < HALF_W; i++)
        begin
            lo_m_calc[i] = (SHIFT_W'(i) < lo_w_calc);
        end
        hi_m_calc = HALF_W'(bmask_reg >> lo_w_calc);
    end

    // odd rounds mix the low half into the high half, the even round the reverse
    assign mix_src = rnd_reg[0] ? MIX_W'(lo_reg) : MIX_W'(hi_reg);
    assign keyed   = mix_src ^ (key_reg + kip_pkg::round_offset(rnd_reg));
    assign premix  = keyed ^ (keyed >> kip_pkg::XS_PRE);
    assign mid_mix = acc_reg ^ (acc_reg >> kip_pkg::XS_MID);
    assign final_mix = acc_reg ^ (acc_reg >> kip_pkg::XS_POST);

    // shared multiplier: 64-bit low product from three 32x32 partial products
    assign mconst = (ctrl.mc == kip_pkg::MC_B) ? kip_pkg::MIX_MUL_B : kip_pkg::MIX_MUL_A;
    assign mul_a  = (ctrl.op == kip_pkg::UOP_MUL_HL) ? h_reg[2*MUL_W-1:MUL_W]
                                                     : h_reg[MUL_W-1:0];
    assign mul_b  = (ctrl.op == kip_pkg::UOP_MUL_LH) ? mconst[2*MUL_W-1:MUL_W]
                                                     : mconst[MUL_W-1:0];
    assign prod   = (2*MUL_W)'(mul_a) * (2*MUL_W)'(mul_b);

    // split the value into halves and join them back
    assign split_hi = HALF_W'(val_reg >> lo_w_reg) & hi_m_reg;
    assign split_lo = HALF_W'(val_reg) & lo_m_reg;
    assign joined   = (VAL_W'(hi_reg) << lo_w_reg) | VAL_W'(lo_reg);

    // ------------------------------------------------------------------
    // sequencer: next state, datapath updates and result capture
    // ------------------------------------------------------------------

    always_comb
    begin
        domain_next    = domain_reg;
        key_next       = key_reg;
        state_next     = state_reg;
        pc_next        = pc_reg;
        rnd_next       = rnd_reg;
        bmask_next     = bmask_reg;
        lo_w_next      = lo_w_reg;
        lo_m_next      = lo_m_reg;
        hi_m_next      = hi_m_reg;
        val_next       = val_reg;
        hi_next        = hi_reg;
        lo_next        = lo_reg;
        h_next         = h_reg;
        acc_next       = acc_reg;
        res_valid_next = res_valid_reg;
        perm_next      = perm_reg;
        bad_next       = bad_reg;
        finish         = 1'b0;
        finish_bad     = 1'b0;

        // configuration writes, taken at any time
        if (cfg_valid)
        begin
            case (cfg_index)
                kip_pkg::REG_DOMAIN_SIZE: domain_next = cfg_data[DS_W-1:0];
                kip_pkg::REG_KEY_SEED:    key_next    = cfg_data;
                default:                  ;
            endcase
        end

        // result transaction taken by the consumer
        if (res_valid_reg && result_ready)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            kip_pkg::SEQ_IDLE:
            begin
                if (source_valid)
                begin
                    val_next   = VAL_W'(source_index);
                    pc_next    = kip_pkg::ENTRY_START;
                    state_next = kip_pkg::SEQ_RUN;
                end
            end

            kip_pkg::SEQ_RUN:
            begin
                // datapath operation of this step
                case (ctrl.op)
                    kip_pkg::UOP_SMEAR:
                    begin
                        bmask_next = smear;
                    end
                    kip_pkg::UOP_GEOM:
                    begin
                        lo_w_next = lo_w_calc;
                        lo_m_next = lo_m_calc;
                        hi_m_next = hi_m_calc;
                    end
                    kip_pkg::UOP_SPLIT:
                    begin
                        hi_next  = split_hi;
                        lo_next  = split_lo;
                        rnd_next = kip_pkg::FIRST_ROUND;
                    end
                    kip_pkg::UOP_PREMIX:
                    begin
                        h_next = premix;
                    end
                    kip_pkg::UOP_MUL_LL:
                    begin
                        acc_next = prod;
                    end
                    kip_pkg::UOP_MUL_LH,
                    kip_pkg::UOP_MUL_HL:
                    begin
                        acc_next = {acc_reg[2*MUL_W-1:MUL_W] + prod[MUL_W-1:0],
                                    acc_reg[MUL_W-1:0]};
                    end
                    kip_pkg::UOP_XS_MID:
                    begin
                        h_next = mid_mix;
                    end
                    kip_pkg::UOP_APPLY:
                    begin
                        if (rnd_reg[0])
                        begin
                            hi_next = (hi_reg ^ final_mix[HALF_W-1:0]) & hi_m_reg;
                        end
                        else
                        begin
                            lo_next = (lo_reg ^ final_mix[HALF_W-1:0]) & lo_m_reg;
                        end
                        rnd_next = rnd_reg + RND_W'(1);
                    end
                    kip_pkg::UOP_JOIN:
                    begin
                        val_next = joined;
                    end
                    default:
                    begin
                        // range guard and walk test only steer the step counter
                    end
                endcase

                // step counter
                case (ctrl.br)
                    kip_pkg::BR_GUARD:
                    begin
                        if (val_ge)
                        begin
                            finish     = 1'b1;
                            finish_bad = 1'b1;
                        end
                        else
                        begin
                            pc_next = pc_reg + PC_W'(1);
                        end
                    end
                    kip_pkg::BR_ROUND:
                    begin
                        pc_next = (rnd_reg != kip_pkg::FEISTEL_ROUNDS) ? ctrl.target
                                                                       : pc_reg + PC_W'(1);
                    end
                    kip_pkg::BR_WALK:
                    begin
                        if (val_ge)
                        begin
                            pc_next = ctrl.target;
                        end
                        else
                        begin
                            finish = 1'b1;
                        end
                    end
                    default:
                    begin
                        pc_next = pc_reg + PC_W'(1);
                    end
                endcase

                // a finishing step holds until the output register can take it
                if (finish && out_free)
                begin
                    state_next     = kip_pkg::SEQ_IDLE;
                    res_valid_next = 1'b1;
                    perm_next      = finish_bad ? '0 : val_reg[INDEX_BITS-1:0];
                    bad_next       = finish_bad;
                end
            end

            default:
            begin
                state_next = kip_pkg::SEQ_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // state
    // ------------------------------------------------------------------

    // control and configuration state, cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= kip_pkg::SEQ_IDLE;
            pc_reg        <= kip_pkg::ENTRY_START;
            res_valid_reg <= 1'b0;
            domain_reg    <= DS_W'(1);
            key_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            res_valid_reg <= res_valid_next;
            domain_reg    <= domain_next;
            key_reg       <= key_next;
        end
    end

    // datapath and result payload, no reset needed
    always_ff @(posedge clk)
    begin
        rnd_reg   <= rnd_next;
        bmask_reg <= bmask_next;
        lo_w_reg  <= lo_w_next;
        lo_m_reg  <= lo_m_next;
        hi_m_reg  <= hi_m_next;
        val_reg   <= val_next;
        hi_reg    <= hi_next;
        lo_reg    <= lo_next;
        h_reg     <= h_next;
        acc_reg   <= acc_next;
        perm_reg  <= perm_next;
        bad_reg   <= bad_next;
    end

    // ------------------------------------------------------------------
    // ports
    // ------------------------------------------------------------------

    assign cfg_ready      = 1'b1;
    assign source_ready   = (state_reg == kip_pkg::SEQ_IDLE);
    assign result_valid   = res_valid_reg;
    assign permuted_index = perm_reg;
    assign bad_request    = bad_reg;

endmodule

[sim/tb_keyed_index_permutation.sv]
// tb_keyed_index_permutation: self-checking testbench of the keyed index permutation
// drives request and register transactions, predicts each result and checks it in order
// depends on kip_pkg and rtl/core/keyed_index_permutation.sv

module tb_keyed_index_permutation;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RANDOM_ITEMS = 900;

    // splitmix constants of the permutation
    localparam logic [63:0] WEYL_INC = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [63:0] MIX_K1   = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [63:0] MIX_K2   = 64'h94D0_49BB_1331_11EB;

    typedef struct packed
    {
        logic [31:0] pos;
        logic        bad;
    } perm_result_t;

    // holds the register copy and the results still owed by the block
    class perm_scoreboard;
        logic [32:0]  domain;
        logic [63:0]  key;
        perm_result_t owed[$];
        int           mismatches;
        int           checked;
        int           rejected;

        function new();
            domain     = 33'd1;
            key        = '0;
            mismatches = 0;
            checked    = 0;
            rejected   = 0;
        endfunction

        function void load_reg(logic [kip_pkg::CFG_IDX_W-1:0] sel, logic [63:0] data);
            case (sel)
                kip_pkg::REG_DOMAIN_SIZE: domain = data[32:0];
                kip_pkg::REG_KEY_SEED:    key    = data;
                default:                  ;
            endcase
        endfunction

        function logic [63:0] half_hash(logic [63:0] half, int unsigned rnd);
            logic [63:0] h;
            h = half ^ (key + WEYL_INC * 64'(rnd));
            h = h ^ (h >> 30);
            h = h * MIX_K1;
            h = h ^ (h >> 27);
            h = h * MIX_K2;
            h = h ^ (h >> 31);
            return h;
        endfunction

        function logic [63:0] feistel_pass(logic [63:0] v, int unsigned b);
            int unsigned lo_w;
            int unsigned hi_w;
            logic [63:0] lo_m;
            logic [63:0] hi_m;
            logic [63:0] hi;
            logic [63:0] lo;
            lo_w = b / 2;
            hi_w = b - lo_w;
            lo_m = (64'd1 << lo_w) - 64'd1;
            hi_m = (64'd1 << hi_w) - 64'd1;
            hi   = (v >> lo_w) & hi_m;
            lo   = v & lo_m;
            for (int unsigned r = 1; r <= 3; r++)
            begin
                if (r[0])
                    hi = (hi ^ half_hash(lo, r)) & hi_m;
                else
                    lo = (lo ^ half_hash(hi, r)) & lo_m;
            end
            return (hi << lo_w) | lo;
        endfunction

        function perm_result_t permute(logic [31:0] idx);
            perm_result_t res;
            logic [63:0]  n;
            logic [63:0]  span;
            logic [63:0]  v;
            int unsigned  b;
            n   = 64'(domain);
            res = '0;
            if (n == 0 || 64'(idx) >= n)
            begin
                res.bad = 1'b1;
                return res;
            end
            // bit width of n-1
            span = n - 64'd1;
            b    = 0;
            while (span != 0)
            begin
                span = span >> 1;
                b++;
            end
            // cycle walk until the value lands inside the domain
            v = 64'(idx);
            do
                v = feistel_pass(v, b);
            while (v >= n);
            res.pos = v[31:0];
            return res;
        endfunction

        function void note_request(logic [31:0] idx);
            owed.push_back(permute(idx));
        endfunction

        function void check_result(logic [31:0] pos, logic bad);
            perm_result_t want;
            if (owed.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result pos=%h bad=%b", $time, pos, bad);
                return;
            end
            want = owed.pop_front();
            checked++;
            if (want.bad)
                rejected++;
            if (pos !== want.pos)
            begin
                mismatches++;
                $display("%0t: permuted_index expected %h actual %h", $time, want.pos, pos);
            end
            if (bad !== want.bad)
            begin
                mismatches++;
                $display("%0t: bad_request expected %b actual %b", $time, want.bad, bad);
            end
        endfunction

        function int pending();
            return owed.size();
        endfunction
    endclass

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [kip_pkg::CFG_IDX_W-1:0]   cfg_index;
    logic [kip_pkg::CFG_DATA_W-1:0]  cfg_data;
    logic                            source_valid;
    logic                            source_ready;
    logic [31:0]                     source_index;
    logic                            result_valid;
    logic                            result_ready;
    logic [31:0]                     permuted_index;
    logic                            bad_request;

    perm_scoreboard sb = new();
    bit             steady;      // phase with no idling on either side
    int             settings;    // register settings run through
    int             sent;

    keyed_index_permutation dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .source_valid   (source_valid),
        .source_ready   (source_ready),
        .source_index   (source_index),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .permuted_index (permuted_index),
        .bad_request    (bad_request)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // a domain size from one of several families, weighted toward awkward widths
    function automatic logic [32:0] pick_domain();
        logic [32:0] n;
        case ($urandom_range(0, 19))
            0:       n = '0;
            1, 2:    n = 33'($urandom_range(1, 8));
            3:       n = 33'd1 << 32;
            4, 5, 6,
            7, 8:    n = (33'd1 << $urandom_range(1, 31)) + 33'($urandom_range(0, 2)) - 33'd1;
            default: n = 33'($urandom >> $urandom_range(0, 31));
        endcase
        if (n == 0 && $urandom_range(0, 1))
            n = 33'd1;
        return n;
    endfunction

    function automatic logic [63:0] pick_key();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // mostly indexes inside the domain, the rest out of range, edges and noise
    function automatic logic [31:0] pick_index();
        logic [63:0] n;
        logic [63:0] wide;
        int          r;
        n    = 64'(sb.domain);
        wide = {$urandom, $urandom};
        r    = $urandom_range(0, 99);
        if (r < 80 && n != 0)
            return 32'(wide % n);
        if (r < 88 && n < 64'h1_0000_0000)
            return 32'(n + wide % (64'h1_0000_0000 - n));
        if (r < 94)
        begin
            case ($urandom_range(0, 3))
                0:       return '0;
                1:       return 32'(n - 64'd1);
                2:       return 32'(n);
                default: return '1;
            endcase
        end
        return $urandom;
    endfunction

    // one register transaction; valid stays up for a following write
    task automatic write_reg(input logic [kip_pkg::CFG_IDX_W-1:0] sel, input logic [63:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.load_reg(sel, data);
    endtask

    // block is idle here; bits above the domain size width carry random junk
    task automatic set_config(input logic [32:0] n, input logic [63:0] k);
        logic [63:0] dword;
        dword       = {$urandom, $urandom};
        dword[32:0] = n;
        if ($urandom_range(0, 1))
        begin
            write_reg(kip_pkg::REG_DOMAIN_SIZE, dword);
            write_reg(kip_pkg::REG_KEY_SEED, k);
        end
        else
        begin
            write_reg(kip_pkg::REG_KEY_SEED, k);
            write_reg(kip_pkg::REG_DOMAIN_SIZE, dword);
        end
        cfg_valid <= 1'b0;
        settings++;
    endtask

    // one request transaction, an optional gap in front of it
    task automatic send_index(input logic [31:0] idx);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            source_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        source_valid <= 1'b1;
        source_index <= idx;
        @(posedge clk);
        while (!source_ready)
            @(posedge clk);
        sb.note_request(idx);
        sent++;
    endtask

    // drop valid and let every owed result drain before the next setting
    task automatic close_phase();
        source_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // result side: random backpressure, check every accepted transaction
    initial
    begin
        int hold;
        hold         = 0;
        result_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && result_ready)
                sb.check_result(permuted_index, bad_request);
            if (hold > 0)
            begin
                hold--;
                result_ready <= 1'b0;
            end
            else
            begin
                result_ready <= 1'b1;
                hold = pick_gap();
            end
        end
    end

    // watchdog
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("timeout after %0d cycles, %0d results owed", CYCLE_LIMIT, sb.pending());
        $display("tb_keyed_index_permutation NOT OK");
        $finish;
    end

    initial
    begin
        int count;
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        source_valid = 1'b0;
        source_index = '0;
        steady       = 1'b0;
        settings     = 0;
        sent         = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset setting: unit domain, zero key
        send_index(32'd0);
        send_index(32'd1);
        send_index('1);
        close_phase();

        // empty domain rejects everything
        set_config(33'd0, '0);
        send_index(32'd0);
        send_index('1);
        close_phase();

        // full 32-bit domain, all-ones key
        set_config(33'd1 << 32, '1);
        send_index(32'd0);
        send_index('1);
        send_index(32'h8000_0000);
        close_phase();

        // two elements: empty low half, one-bit high half
        set_config(33'd2, '0);
        send_index(32'd0);
        send_index(32'd1);
        send_index(32'd2);
        close_phase();

        // three elements in a four-element block, walks needed
        set_config(33'd3, 64'h0123_4567_89AB_CDEF);
        send_index(32'd0);
        send_index(32'd1);
        send_index(32'd2);
        send_index(32'd3);
        close_phase();

        // just past a power of two: widest walk ratio
        set_config(33'h0_8000_0001, pick_key());
        send_index(32'd0);
        send_index(32'h8000_0000);
        send_index(32'h8000_0001);
        close_phase();

        // random settings, each with a short burst of requests
        count = sent + RANDOM_ITEMS;
        while (sent < count)
        begin
            steady = ($urandom_range(0, 3) == 0);
            set_config(pick_domain(), pick_key());
            repeat ($urandom_range(10, 50))
                send_index(pick_index());
            close_phase();
        end

        $display("checked %0d results, %0d of them rejected requests", sb.checked, sb.rejected);
        $display("over %0d register settings with random stalls on both channels", settings);
        if (sb.mismatches == 0)
            $display("tb_keyed_index_permutation OK");
        else
            $display("tb_keyed_index_permutation NOT OK");
        $finish;
    end

endmodule
